/* sv/mfs_pkg.sv */
package mfs_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DIV_QW = 24;
	localparam int DIV_DW = 33;
	localparam int DIV_CW = $clog2(DIV_QW + 1);

	localparam logic [25:0] KI = 26'd54212280;
	localparam logic [26:0] KC = 27'd85156450;

	localparam logic [3:0] W_LOC_X = 4'd0;
	localparam logic [3:0] W_LOC_Y = 4'd1;
	localparam logic [3:0] W_LOC_Z = 4'd2;
	localparam logic [3:0] W_STR_X = 4'd3;
	localparam logic [3:0] W_STR_Y = 4'd4;
	localparam logic [3:0] W_STR_Z = 4'd5;
	localparam logic [3:0] W_LENGTH = 4'd6;
	localparam logic [3:0] W_EDGE = 4'd7;
	localparam logic [3:0] W_KIND = 4'd8;

	localparam logic [1:0] KIND_DIPOLE = 2'd1;
	localparam logic [1:0] KIND_QUAD = 2'd2;

	typedef enum logic [1:0] {
		ST_EVAL = 2'd0,
		ST_WRITTEN = 2'd1,
		ST_BADKIND = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DER1, S_DER2, S_LOAD, S_CHK, S_DIV1, S_DIV2GO, S_DIV2,
		S_TERM1, S_TERM2, S_NEXT, S_DONE
	} state_t;

	typedef struct packed {
		logic op;
		logic [2:0] slot;
		logic [3:0] word_sel;
		logic signed [31:0] value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} mfs_cmd_t;

	typedef struct packed {
		logic signed [31:0] field_x;
		logic signed [31:0] field_y;
		logic signed [31:0] field_z;
		logic [1:0] status;
	} mfs_result_t;

	typedef struct packed {
		logic [2:0][31:0] loc;
		logic [2:0][31:0] str;
		logic signed [31:0] len;
		logic signed [31:0] edge_len;
		logic signed [31:0] scale;
		logic signed [31:0] core;
		logic [1:0] kind;
	} cell_t;

	// Arithmetic shift right with rounding half away from zero.
	function automatic logic signed [95:0] rsh(input logic signed [95:0] v,
		input int unsigned s);
		logic [95:0] m;
		logic [95:0] h;
		logic [95:0] r;
		h = 96'(1) << (s - 1);
		m = v[95] ? 96'(-v) : 96'(v);
		r = (m + h) >> s;
		return v[95] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
		if (v > 96'sh7FFFFFFF) begin
			return 32'sh7FFFFFFF;
		end else if (v < -96'sh80000000) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

/* sv/mfs_cell.sv */
module mfs_cell import mfs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic shift,
	input cell_t nbr,
	input logic wr_en,
	input cell_t wr_data,
	output cell_t q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (wr_en) begin
			q <= wr_data;
		end else if (shift) begin
			q <= nbr;
		end
	end

endmodule

/* sv/mfs_div.sv */
module mfs_div import mfs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [DIV_DW-1:0] rem0,
	input logic [DIV_QW-1:0] low,
	input logic [DIV_DW-1:0] den,
	output logic done,
	output logic [DIV_QW-1:0] quo
);

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_QW-1:0] sh_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_DW:0] trial;

	assign trial = {rem_q, sh_q[DIV_QW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= (cnt_q == DIV_CW'(1));
			if (go) begin
				cnt_q <= DIV_CW'(DIV_QW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - DIV_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= rem0;
			sh_q <= low;
			den_q <= den;
		end else if (cnt_q != '0) begin
			sh_q <= {sh_q[DIV_QW-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= DIV_DW'(trial - {1'b0, den_q});
				quo <= {quo[DIV_QW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIV_DW-1:0];
				quo <= {quo[DIV_QW-2:0], 1'b0};
			end
		end
	end

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> cnt_q == '0) else $error("divider restarted while running");

endmodule

/* sv/magnet_field_sum_soft_edge.sv */
// Magnet field summer. A write to the length or edge length word also recomputes the slot's
// core half-length and edge scale. A query walks the ring of slot cells once, one slot per
// step: an empty slot is passed over, an active slot inside its core adds its terms
// directly, and an active slot in its soft edge first runs the two 24-step divisions of
// the shared divider unless its edge scale is zero or it lies far out in the edge. The
// result appears on result for one cycle with done high and must be taken then; busy is
// high while a transfer is being worked on.
module magnet_field_sum_soft_edge import mfs_pkg::*; #(
	parameter int MAX_ELEMENTS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input mfs_cmd_t cmd,
	output logic busy,
	output logic done,
	output mfs_result_t result
);

	localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

	state_t state_q, state_d;
	cell_t cells [MAX_ELEMENTS];
	cell_t cur, wr_cell, h;
	logic ring_shift, wr_en, accept, slot_ok, kind_ok;
	logic [IW-1:0] wr_idx, slot_q, cnt_q;
	mfs_cmd_t cmd_q;
	logic any_q;
	logic [1:0] k_q;
	logic signed [32:0] lx_q, ly_q, lz_q;
	logic signed [34:0] zr_q;
	logic [16:0] f_q;
	logic [32:0] u_q;
	logic signed [39:0] t_q;
	logic signed [47:0] acc_q [3];
	logic signed [63:0] pki_q, pc_q;
	logic div_go, div_done;
	logic [DIV_DW-1:0] div_rem0, div_den;
	logic [DIV_QW-1:0] div_low, div_q;
	logic [31:0] as;
	logic [33:0] numer2;
	logic big;
	logic h_valid;
	logic der_go;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_ELEMENTS; gi++) begin : g_cell
			mfs_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.shift(ring_shift),
				.nbr(cells[(gi + 1) % MAX_ELEMENTS]),
				.wr_en(wr_en && (wr_idx == IW'(gi))),
				.wr_data(wr_cell),
				.q(cells[gi])
			);
		end
	endgenerate

	mfs_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.go(div_go),
		.rem0(div_rem0),
		.low(div_low),
		.den(div_den),
		.done(div_done),
		.quo(div_q)
	);

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign h = cells[0];
	assign h_valid = (h.kind == KIND_DIPOLE) || (h.kind == KIND_QUAD);
	assign slot_ok = int'(cmd.slot) < MAX_ELEMENTS;
	assign kind_ok = (cmd.value == 32'(KIND_DIPOLE)) || (cmd.value == 32'(KIND_QUAD));
	assign der_go = accept && !cmd.op && slot_ok &&
		(cmd.word_sel == W_LENGTH || cmd.word_sel == W_EDGE);
	assign wr_idx = (state_q == S_DER1 || state_q == S_DER2) ? slot_q : IW'(cmd.slot);
	assign cur = cells[wr_idx];

	assign as = h.scale[31] ? 32'(-h.scale) : 32'(h.scale);
	assign numer2 = 34'(64'd1 << 32) + 34'(u_q >> 1);

	always_comb begin
		logic [49:0] n1;
		n1 = {zr_q[32:0], 16'b0} + 50'(as >> 1);
		big = {6'b0, n1} >= {as, 24'b0};
		div_rem0 = DIV_DW'(n1 >> 24);
		div_low = n1[23:0];
		div_den = DIV_DW'(as);
		if (state_q == S_DIV2GO) begin
			div_rem0 = DIV_DW'(numer2 >> 24);
			div_low = numer2[23:0];
			div_den = u_q;
		end
	end

	always_comb begin
		wr_cell = cur;
		case (state_q)
			S_DER2: begin
				wr_cell.scale = sat32(rsh(96'(pki_q), 26));
				wr_cell.core = sat32(rsh(96'(pc_q), 27));
			end
			default: begin
				case (cmd.word_sel)
					W_LOC_X: wr_cell.loc[0] = cmd.value;
					W_LOC_Y: wr_cell.loc[1] = cmd.value;
					W_LOC_Z: wr_cell.loc[2] = cmd.value;
					W_STR_X: wr_cell.str[0] = cmd.value;
					W_STR_Y: wr_cell.str[1] = cmd.value;
					W_STR_Z: wr_cell.str[2] = cmd.value;
					W_LENGTH: wr_cell.len = cmd.value;
					W_EDGE: wr_cell.edge_len = cmd.value;
					W_KIND: wr_cell.kind = cmd.value[1:0];
					default: wr_cell = cur;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ring_shift = 1'b0;
		wr_en = 1'b0;
		div_go = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept && cmd.op) begin
					state_d = S_LOAD;
				end else if (accept && slot_ok) begin
					wr_en = (cmd.word_sel <= W_EDGE) || (cmd.word_sel == W_KIND && kind_ok);
					if (cmd.word_sel == W_LENGTH || cmd.word_sel == W_EDGE) begin
						state_d = S_DER1;
					end
				end
			end
			S_DER1: state_d = S_DER2;
			S_DER2: begin
				wr_en = 1'b1;
				state_d = S_IDLE;
			end
			S_LOAD: state_d = h_valid ? S_CHK : S_NEXT;
			S_CHK: begin
				if (zr_q < 0 || h.scale == 0 || big) begin
					state_d = S_TERM1;
				end else begin
					div_go = 1'b1;
					state_d = S_DIV1;
				end
			end
			S_DIV1: if (div_done) state_d = S_DIV2GO;
			S_DIV2GO: begin
				div_go = 1'b1;
				state_d = S_DIV2;
			end
			S_DIV2: if (div_done) state_d = S_TERM1;
			S_TERM1: state_d = S_TERM2;
			S_TERM2: state_d = (k_q == 2'd2) ? S_NEXT : S_TERM1;
			S_NEXT: begin
				ring_shift = 1'b1;
				state_d = (cnt_q == IW'(MAX_ELEMENTS - 1)) ? S_DONE : S_LOAD;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= (accept && !cmd.op && !der_go) || state_q == S_DER2 ||
				state_q == S_DONE;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == S_NEXT && cnt_q != IW'(MAX_ELEMENTS - 1)) begin
				cnt_q <= cnt_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		logic signed [31:0] st;
		logic signed [32:0] sp;
		logic signed [64:0] prod;
		logic signed [95:0] pr;
		logic signed [57:0] pf;
		logic signed [47:0] term;
		logic [47:0] sq;
		logic [33:0] sq2;
		logic signed [32:0] lzn;
		logic signed [33:0] labs;
		logic signed [31:0] core;
		st = $signed(h.str[k_q]);
		sp = (k_q == 2'd0) ? ly_q : (k_q == 2'd1) ? lx_q : lz_q;
		prod = 65'(st) * 65'(sp);
		pr = rsh(96'(prod), FRAC_BITS);
		pf = 58'(t_q) * 58'($signed({1'b0, f_q}));
		term = (zr_q < 0) ? 48'(t_q) : 48'(rsh(96'(pf), FRAC_BITS));
		sq = 48'(div_q) * 48'(div_q);
		sq2 = 34'(div_q[16:0]) * 34'(div_q[16:0]);
		lzn = 33'(cmd_q.pos_z) - 33'($signed(h.loc[2]));
		labs = (lzn < 0) ? -34'(lzn) : 34'(lzn);
		core = (h.kind == KIND_DIPOLE) ? h.core : 32'(rsh(96'(h.len), 1));
		if (accept) begin
			cmd_q <= cmd;
			slot_q <= IW'(cmd.slot);
			any_q <= 1'b0;
			acc_q[0] <= '0;
			acc_q[1] <= '0;
			acc_q[2] <= '0;
		end
		case (state_q)
			S_DER1: begin
				pki_q <= 64'(cur.edge_len) * 64'($signed({1'b0, KI}));
				pc_q <= (64'(cur.len) <<< 26) - 64'(cur.edge_len) * 64'($signed({1'b0, KC}));
			end
			S_LOAD: begin
				lx_q <= 33'(cmd_q.pos_x) - 33'($signed(h.loc[0]));
				ly_q <= 33'(cmd_q.pos_y) - 33'($signed(h.loc[1]));
				lz_q <= lzn;
				if (h_valid) begin
					any_q <= 1'b1;
				end
			end
			S_CHK: begin
				zr_q <= zr_q;
				k_q <= 2'd0;
				if (h.scale == 0) begin
					f_q <= (zr_q == 0) ? 17'(1 << FRAC_BITS) : 17'd0;
				end else if (big) begin
					f_q <= '0;
				end
			end
			S_DIV1: begin
				if (div_done) begin
					u_q <= 33'(1 << FRAC_BITS) + 33'((sq + 48'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
				end
			end
			S_DIV2: begin
				if (div_done) begin
					f_q <= 17'((sq2 + 34'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
				end
			end
			S_TERM1: begin
				if (h.kind == KIND_DIPOLE) begin
					t_q <= 40'(st);
				end else if (pr > 96'sh4000000000) begin
					t_q <= 40'sh4000000000;
				end else if (pr < -96'sh4000000000) begin
					t_q <= -40'sh4000000000;
				end else begin
					t_q <= pr[39:0];
				end
			end
			S_TERM2: begin
				acc_q[k_q] <= acc_q[k_q] + term;
				k_q <= k_q + 2'd1;
			end
			default: begin
			end
		endcase
		if (state_q == S_LOAD) begin
			zr_q <= 35'(labs) - 35'(core);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !cmd.op) begin
			result.field_x <= '0;
			result.field_y <= '0;
			result.field_z <= '0;
			result.status <= (slot_ok && cmd.word_sel == W_KIND && !kind_ok) ?
				ST_BADKIND : ST_WRITTEN;
		end else if (state_q == S_DER2) begin
			result.field_x <= '0;
			result.field_y <= '0;
			result.field_z <= '0;
			result.status <= ST_WRITTEN;
		end else if (state_q == S_DONE) begin
			result.field_x <= any_q ? sat32(96'(acc_q[0])) : '0;
			result.field_y <= any_q ? sat32(96'(acc_q[1])) : '0;
			result.field_z <= any_q ? sat32(96'(acc_q[2])) : '0;
			result.status <= any_q ? ST_EVAL : ST_EMPTY;
		end
	end

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_EMPTY |->
		result.field_x == 0 && result.field_y == 0 && result.field_z == 0)
		else $error("empty table gave a nonzero field");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_WRITTEN || result.status == ST_BADKIND) |->
		result.field_x == 0 && result.field_y == 0 && result.field_z == 0)
		else $error("write transfer gave a nonzero field");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.op |=> busy)
		else $error("query did not hold the block busy");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_IDLE || $past(state_q) == S_DER2 ||
		$past(state_q) == S_DONE)
		else $error("result strobe from an unexpected state");

endmodule

/* bench/magnet_field_sum_soft_edge_test.sv */
module magnet_field_sum_soft_edge_test;
	import mfs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 8;
	localparam int QUIET_LIMIT = 20000;
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;
	localparam longint ONE = 64'sd1 << FRAC_BITS;
	localparam longint TERM_LIM = 64'sd1 << 38;
	localparam longint KI_Q26 = 54212280;
	localparam longint KC_Q26 = 85156450;

	logic clk;
	logic arst_n;
	logic start;
	mfs_cmd_t cmd;
	logic busy;
	logic done;
	mfs_result_t result;

	mfs_cmd_t pending_cmds[$];
	mfs_result_t expected_fields[$];
	bit stimulus_done;
	bit quiet_phase;
	int mismatches;
	int quiet_cycles;
	int n_writes, n_queries, n_results;

	int m_loc[SLOTS][3];
	int m_str[SLOTS][3];
	int m_len[SLOTS];
	int m_edge[SLOTS];
	int m_scale[SLOTS];
	int m_core[SLOTS];
	logic [1:0] m_kind[SLOTS];

	magnet_field_sum_soft_edge #(.MAX_ELEMENTS(SLOTS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint round_shift(longint v, int s);
		longint h;
		h = 64'sd1 << (s - 1);
		if (v < 0) begin
			return -((-v + h) >>> s);
		end
		return (v + h) >>> s;
	endfunction

	function automatic int clamp32(longint v);
		if (v > 64'sd2147483647) begin
			return 32'h7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'h80000000;
		end
		return int'(v);
	endfunction

	function automatic longint clamp_term(longint v);
		if (v > TERM_LIM) begin
			return TERM_LIM;
		end else if (v < -TERM_LIM) begin
			return -TERM_LIM;
		end
		return v;
	endfunction

	function automatic void recompute_edge(int i);
		longint e, l;
		e = m_edge[i];
		l = m_len[i];
		m_scale[i] = clamp32(round_shift(e * KI_Q26, 26));
		m_core[i] = clamp32(round_shift((l <<< 26) - e * KC_Q26, 27));
	endfunction

	function automatic longint soft_edge_factor(longint zr, int s);
		longint unsigned as, r, u, v, half;
		half = ONE >> 1;
		if (s == 0) begin
			return (zr == 0) ? ONE : 0;
		end
		as = (s < 0) ? longint'(-longint'(s)) : longint'(s);
		r = ((longint'(zr) << FRAC_BITS) + as / 2) / as;
		if (r >= (longint'(256) << FRAC_BITS)) begin
			return 0;
		end
		u = ONE + ((r * r + half) >> FRAC_BITS);
		v = ((longint'(ONE) << FRAC_BITS) + u / 2) / u;
		return longint'((v * v + half) >> FRAC_BITS);
	endfunction

	function automatic mfs_result_t field_sum(mfs_cmd_t c);
		mfs_result_t r;
		longint acc[3];
		longint lp[3];
		longint pos[3];
		longint lz, core, zr, f, term, sp;
		bit any;
		r = '0;
		acc = '{0, 0, 0};
		any = 0;
		if (c.op == OP_WRITE) begin
			r.status = ST_WRITTEN;
			if (c.word_sel <= W_LOC_Z) begin
				m_loc[c.slot][c.word_sel] = c.value;
			end else if (c.word_sel <= W_STR_Z) begin
				m_str[c.slot][c.word_sel - W_STR_X] = c.value;
			end else if (c.word_sel == W_LENGTH) begin
				m_len[c.slot] = c.value;
				recompute_edge(int'(c.slot));
			end else if (c.word_sel == W_EDGE) begin
				m_edge[c.slot] = c.value;
				recompute_edge(int'(c.slot));
			end else if (c.word_sel == W_KIND) begin
				if (c.value == KIND_DIPOLE || c.value == KIND_QUAD) begin
					m_kind[c.slot] = c.value[1:0];
				end else begin
					r.status = ST_BADKIND;
				end
			end
			return r;
		end
		pos[0] = c.pos_x;
		pos[1] = c.pos_y;
		pos[2] = c.pos_z;
		for (int i = 0; i < SLOTS; i++) begin
			if (m_kind[i] != KIND_DIPOLE && m_kind[i] != KIND_QUAD) begin
				continue;
			end
			any = 1;
			for (int k = 0; k < 3; k++) begin
				lp[k] = pos[k] - longint'(m_loc[i][k]);
			end
			lz = (lp[2] < 0) ? -lp[2] : lp[2];
			core = (m_kind[i] == KIND_DIPOLE) ? longint'(m_core[i]) :
				round_shift(m_len[i], 1);
			zr = lz - core;
			f = (zr >= 0) ? soft_edge_factor(zr, m_scale[i]) : 0;
			for (int k = 0; k < 3; k++) begin
				if (m_kind[i] == KIND_DIPOLE) begin
					term = m_str[i][k];
				end else begin
					sp = (k == 0) ? lp[1] : (k == 1) ? lp[0] : lp[2];
					term = clamp_term(round_shift(longint'(m_str[i][k]) * sp, FRAC_BITS));
				end
				if (zr >= 0) begin
					term = round_shift(term * f, FRAC_BITS);
				end
				acc[k] += term;
			end
		end
		if (any) begin
			r.field_x = clamp32(acc[0]);
			r.field_y = clamp32(acc[1]);
			r.field_z = clamp32(acc[2]);
			r.status = ST_EVAL;
		end else begin
			r.status = ST_EMPTY;
		end
		return r;
	endfunction

	function automatic mfs_cmd_t make_write(int s, logic [3:0] w, int v);
		mfs_cmd_t c;
		c.op = OP_WRITE;
		c.slot = 3'(s);
		c.word_sel = w;
		c.value = v;
		c.pos_x = $urandom;
		c.pos_y = $urandom;
		c.pos_z = $urandom;
		return c;
	endfunction

	function automatic mfs_cmd_t make_query(int x, int y, int z);
		mfs_cmd_t c;
		c.op = OP_QUERY;
		c.slot = 3'($urandom);
		c.word_sel = 4'($urandom);
		c.value = $urandom;
		c.pos_x = x;
		c.pos_y = y;
		c.pos_z = z;
		return c;
	endfunction

	function automatic int modest_value();
		int v;
		v = $urandom_range(0, 20 * 65536);
		return $urandom_range(0, 1) ? v : -v;
	endfunction

	function automatic int any_value();
		case ($urandom_range(0, 3))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_cmd(mfs_cmd_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	task automatic fill_slot(int s);
		for (int w = W_LOC_X; w <= W_EDGE; w++) begin
			queue_cmd(make_write(s, 4'(w),
				($urandom_range(0, 9) == 0) ? any_value() : modest_value()));
		end
		queue_cmd(make_write(s, W_KIND, $urandom_range(1, 2)));
	endtask

	initial begin
		int p;
		arst_n = 1'b0;
		stimulus_done = 0;
		for (int i = 0; i < SLOTS; i++) begin
			m_kind[i] = '0;
			m_len[i] = 0;
			m_edge[i] = 0;
			m_scale[i] = 0;
			m_core[i] = 0;
			for (int k = 0; k < 3; k++) begin
				m_loc[i][k] = 0;
				m_str[i][k] = 0;
			end
		end
		queue_cmd(make_query(0, 0, 0));
		queue_cmd(make_write(0, W_KIND, 0));
		queue_cmd(make_write(0, W_KIND, 3));
		queue_cmd(make_write(1, W_KIND, -1));
		queue_cmd(make_write(2, 4'd9, 5));
		queue_cmd(make_write(3, 4'd15, 5));
		queue_cmd(make_write(0, W_STR_Y, 32'h00020000));
		queue_cmd(make_write(0, W_KIND, int'(KIND_DIPOLE)));
		queue_cmd(make_query(0, 0, 0));
		queue_cmd(make_query(0, 0, 32'h00010000));
		queue_cmd(make_write(0, W_LENGTH, 32'h00040000));
		queue_cmd(make_write(0, W_EDGE, 32'h00010000));
		queue_cmd(make_query(0, 0, 32'h00030000));
		queue_cmd(make_query(32'h7FFFFFFF, 32'h80000000, 32'h80000000));
		queue_cmd(make_write(7, W_STR_X, 32'h7FFFFFFF));
		queue_cmd(make_write(7, W_STR_Z, 32'h80000000));
		queue_cmd(make_write(7, W_LENGTH, 32'h7FFFFFFF));
		queue_cmd(make_write(7, W_EDGE, 32'h80000000));
		queue_cmd(make_write(7, W_KIND, int'(KIND_QUAD)));
		queue_cmd(make_query(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
		queue_cmd(make_query(32'h80000000, 32'h80000000, 32'h80000000));
		queue_cmd(make_write(6, W_KIND, int'(KIND_DIPOLE)));
		queue_cmd(make_write(6, W_STR_X, 32'h7FFFFFFF));
		queue_cmd(make_write(7, W_KIND, int'(KIND_DIPOLE)));
		queue_cmd(make_query(0, 0, 0));
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		p = 0;
		while (p < 400) begin
			if ($urandom_range(0, 9) < 3) begin
				fill_slot($urandom_range(0, SLOTS - 1));
				p += 9;
			end else if ($urandom_range(0, 9) == 0) begin
				queue_cmd(make_write($urandom, 4'($urandom), any_value()));
				p++;
			end else if ($urandom_range(0, 3) == 0) begin
				queue_cmd(make_query(any_value(), any_value(), any_value()));
				p++;
			end else begin
				queue_cmd(make_query(modest_value(), modest_value(),
					modest_value()));
				p++;
			end
		end
		stimulus_done = 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			quiet_phase <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_fields.insert(expected_fields.size(), field_sum(cmd));
				if (cmd.op == OP_WRITE) n_writes++;
				else n_queries++;
			end
			if (!(start && busy)) begin
				if (pending_cmds.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 13)) begin
					start <= 1'b1;
					cmd <= pending_cmds.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
			quiet_phase <= (n_writes + n_queries) > 150 && (n_writes + n_queries) < 250;
		end
	end

	always @(posedge clk) begin
		mfs_result_t want;
		if (arst_n && done) begin
			n_results++;
			if (expected_fields.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", result);
			end else begin
				want = expected_fields.pop_front();
				if (result !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result %0d: expected x=%h y=%h z=%h st=%0d, got x=%h y=%h z=%h st=%0d",
							n_results, want.field_x, want.field_y, want.field_z, want.status,
							result.field_x, result.field_y, result.field_z, result.status);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (arst_n);
		while (!(stimulus_done && pending_cmds.size() == 0 && !start
			&& expected_fields.size() == 0) && quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: %0d results outstanding", expected_fields.size());
			$display("magnet_field_sum_soft_edge: mismatch");
			$finish;
		end else begin
			repeat (100) @(posedge clk);
			$display("Ran %0d parameter writes and %0d field queries, %0d results checked.",
				n_writes, n_queries, n_results);
			if (mismatches == 0 && expected_fields.size() == 0) begin
				$display("magnet_field_sum_soft_edge: match");
			end else begin
				$display("%0d mismatches", mismatches);
				$display("magnet_field_sum_soft_edge: mismatch");
			end
			$finish;
		end
	end

endmodule

/* filelist.f */
sv/mfs_pkg.sv
sv/mfs_cell.sv
sv/mfs_div.sv
sv/magnet_field_sum_soft_edge.sv
bench/magnet_field_sum_soft_edge_test.sv
